>>> design/c_subset_lexer_assert.svh
// assertion macros for the c subset lexer
// expects clk and rst in the scope of use
`ifndef C_SUBSET_LEXER_ASSERT_SVH
`define C_SUBSET_LEXER_ASSERT_SVH

// same-cycle implication
`define CSL_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c_subset_lexer check failed");

// next-cycle implication
`define CSL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c_subset_lexer check failed");

`endif

>>> design/csl_pkg.sv
// shared types, codes and keyword tables for the c subset lexer
// no dependencies
`default_nettype none

package csl_pkg;

  localparam int unsigned TOKEN_LENGTH_LIMIT_DEF = 255;
  localparam int KW_COUNT = 10;
  localparam int KW_MAXLEN = 6;

  typedef logic [7:0] byte_t;

  localparam logic [2:0] KIND_KEYWORD  = 3'd0;
  localparam logic [2:0] KIND_IDENT    = 3'd1;
  localparam logic [2:0] KIND_NUMBER   = 3'd2;
  localparam logic [2:0] KIND_OPERATOR = 3'd3;
  localparam logic [2:0] KIND_SYMBOL   = 3'd4;
  localparam logic [2:0] KIND_COMMENT  = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN  = 3'd6;

  localparam byte_t CH_SLASH = 8'h2f;
  localparam byte_t CH_NL    = 8'h0a;
  localparam byte_t CH_UNDER = 8'h5f;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  kwn;
    logic [7:0]  ch;
    logic [7:0]  len;
    logic [31:0] start;
    logic        last;
  } tok_t;

  localparam byte_t KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
    '{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00},  // int
    '{8'h66, 8'h6c, 8'h6f, 8'h61, 8'h74, 8'h00},  // float
    '{8'h63, 8'h68, 8'h61, 8'h72, 8'h00, 8'h00},  // char
    '{8'h64, 8'h6f, 8'h75, 8'h62, 8'h6c, 8'h65},  // double
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},  // if
    '{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00},  // else
    '{8'h66, 8'h6f, 8'h72, 8'h00, 8'h00, 8'h00},  // for
    '{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65, 8'h00},  // while
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e},  // return
    '{8'h76, 8'h6f, 8'h69, 8'h64, 8'h00, 8'h00}   // void
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd3, 3'd5, 3'd4, 3'd6, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6, 3'd4
  };

  function automatic logic is_alpha(byte_t c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(byte_t c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(byte_t c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_word_char(byte_t c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDER;
  endfunction

  function automatic logic is_operator(byte_t c);
    return c == 8'h2b || c == 8'h2d || c == 8'h2a || c == 8'h3d;
  endfunction

  function automatic logic is_symbol(byte_t c);
    return c == 8'h3b || c == 8'h2c || c == 8'h28 || c == 8'h29 ||
           c == 8'h7b || c == 8'h7d;
  endfunction

endpackage

`default_nettype wire

>>> design/c_subset_lexer.sv
// c subset lexer top level: byte stream in, token words out
// depends on csl_pkg and c_subset_lexer_assert.svh
//
// channel  direction  word                          handshake
// in       input      byte_value, end_of_stream     in_valid / in_stall
// out      output     token fields, last_of_run     out_valid / out_stall
//
// one byte per cycle while in_stall is low; the state update and its tokens
// are formed in the accepting cycle; the first token shows the cycle after
// a byte giving two tokens (a finished run plus a one-char or flushed token)
// holds the second in a spare register, stalling input until it is output
// input is taken while no spare token waits and output is empty or draining
// synchronous active-high reset clears scan state, offset and valid flags
`default_nettype none

`include "c_subset_lexer_assert.svh"

module c_subset_lexer
  import csl_pkg::*;
#(
  parameter int unsigned TOKEN_LENGTH_LIMIT = TOKEN_LENGTH_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  byte_value,
  input  wire logic        end_of_stream,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       token_kind,
  output logic [3:0]       keyword_number,
  output logic [7:0]       token_char,
  output logic [7:0]       token_length,
  output logic [31:0]      token_start,
  output logic             last_of_run
);

  localparam int LEN_W = $clog2(TOKEN_LENGTH_LIMIT + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(TOKEN_LENGTH_LIMIT);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_WORD    = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_SLASH   = 3'd3;
  localparam logic [2:0] MODE_COMMENT = 3'd4;

  logic [2:0]       mode;
  logic [LEN_W-1:0] run_length;
  logic [9:0]       cand;
  logic [31:0]      run_start;
  logic [31:0]      byte_offset;

  tok_t out_tok;
  tok_t extra_tok;
  logic extra_valid;

  function automatic logic [9:0] narrow(logic [9:0] mask, logic [LEN_W-1:0] pos, byte_t c);
    logic [9:0] res;
    logic [2:0] p;
    res = '0;
    p = (pos < LEN_W'(KW_MAXLEN)) ? pos[2:0] : 3'd0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (mask[i] && pos < LEN_W'(KW_LEN[i]) && KW_TEXT[i][p] == c) begin
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [LEN_W-1:0] extend(logic [LEN_W-1:0] len);
    return (len < LEN_MAX) ? len + LEN_W'(1) : len;
  endfunction

  function automatic tok_t flush_tok(logic [2:0] m, logic [LEN_W-1:0] len,
                                     logic [9:0] cm, logic [31:0] st);
    tok_t t;
    logic found;
    t = '0;
    found = 1'b0;
    t.len = len[7:0];
    t.start = st;
    unique case (m)
      MODE_WORD: begin
        t.kind = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
          if (!found && cm[i] && len == LEN_W'(KW_LEN[i])) begin
            found = 1'b1;
            t.kind = KIND_KEYWORD;
            t.kwn = 4'(i);
          end
        end
      end
      MODE_NUMBER:  t.kind = KIND_NUMBER;
      MODE_SLASH: begin
        t.kind = KIND_OPERATOR;
        t.ch = CH_SLASH;
        t.len = 8'd1;
      end
      MODE_COMMENT: t.kind = KIND_COMMENT;
      default:      t.kind = KIND_UNKNOWN;
    endcase
    return t;
  endfunction

  logic             accept;
  logic             pop;
  logic [2:0]       mode_mid;
  logic [LEN_W-1:0] len_mid;
  logic [9:0]       cand_mid;
  logic [31:0]      start_mid;
  logic             taken;
  logic             a_v;
  logic             b_v;
  logic             c_v;
  tok_t             a_t;
  tok_t             b_t;
  tok_t             c_t;
  tok_t             r1;
  tok_t             r2;
  logic             r1_v;
  logic             r2_v;

  assign pop      = out_valid && !out_stall;
  assign in_stall = extra_valid || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    mode_mid  = mode;
    len_mid   = run_length;
    cand_mid  = cand;
    start_mid = run_start;
    taken     = 1'b0;
    a_v       = 1'b0;
    a_t       = flush_tok(mode, run_length, cand, run_start);
    b_v       = 1'b0;
    b_t       = '0;

    unique case (mode)
      MODE_WORD: begin
        if (is_word_char(byte_value)) begin
          cand_mid = narrow(cand, run_length, byte_value);
          len_mid  = extend(run_length);
          taken    = 1'b1;
        end else begin
          a_v = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(byte_value)) begin
          len_mid = extend(run_length);
          taken   = 1'b1;
        end else begin
          a_v = 1'b1;
        end
      end
      MODE_SLASH: begin
        if (byte_value == CH_SLASH) begin
          mode_mid = MODE_COMMENT;
          len_mid  = LEN_W'(2);
          taken    = 1'b1;
        end else begin
          a_v = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (byte_value == CH_NL) begin
          a_v = 1'b1;
        end else begin
          len_mid = extend(run_length);
        end
        taken = 1'b1;
      end
      default: mode_mid = MODE_IDLE;
    endcase

    if (a_v) begin
      mode_mid = MODE_IDLE;
      len_mid  = '0;
      cand_mid = '0;
    end

    if (!taken && !is_space(byte_value)) begin
      if (is_alpha(byte_value) || byte_value == CH_UNDER) begin
        mode_mid  = MODE_WORD;
        start_mid = byte_offset;
        len_mid   = LEN_W'(1);
        cand_mid  = narrow('1, '0, byte_value);
      end else if (is_digit(byte_value)) begin
        mode_mid  = MODE_NUMBER;
        start_mid = byte_offset;
        len_mid   = LEN_W'(1);
      end else if (byte_value == CH_SLASH) begin
        mode_mid  = MODE_SLASH;
        start_mid = byte_offset;
        len_mid   = LEN_W'(1);
      end else begin
        b_v = 1'b1;
        b_t.ch = byte_value;
        b_t.len = 8'd1;
        b_t.start = byte_offset;
        if (is_operator(byte_value)) begin
          b_t.kind = KIND_OPERATOR;
        end else if (is_symbol(byte_value)) begin
          b_t.kind = KIND_SYMBOL;
        end else begin
          b_t.kind = KIND_UNKNOWN;
        end
      end
    end

    c_v = end_of_stream && mode_mid != MODE_IDLE;
    c_t = flush_tok(mode_mid, len_mid, cand_mid, start_mid);

    // a finished run goes first, then the one-char or flushed token
    r2 = b_v ? b_t : c_t;
    r2.last = 1'b1;
    r2_v = a_v && (b_v || c_v);
    r1 = a_v ? a_t : r2;
    r1.last = !r2_v;
    r1_v = a_v || b_v || c_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      run_length  <= '0;
      cand        <= '0;
      run_start   <= '0;
      byte_offset <= '0;
    end else if (accept) begin
      byte_offset <= byte_offset + 32'd1;
      run_start   <= start_mid;
      if (end_of_stream) begin
        mode       <= MODE_IDLE;
        run_length <= '0;
        cand       <= '0;
      end else begin
        mode       <= mode_mid;
        run_length <= len_mid;
        cand       <= cand_mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      extra_valid <= 1'b0;
    end else if (accept) begin
      out_valid   <= r1_v;
      extra_valid <= r2_v;
    end else if (extra_valid && pop) begin
      out_valid   <= 1'b1;
      extra_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tok   <= r1;
      extra_tok <= r2;
    end else if (extra_valid && pop) begin
      out_tok <= extra_tok;
    end
  end

  assign token_kind     = out_tok.kind;
  assign keyword_number = out_tok.kwn;
  assign token_char     = out_tok.ch;
  assign token_length   = out_tok.len;
  assign token_start    = out_tok.start;
  assign last_of_run    = out_tok.last;

  `CSL_ASSERT_NOW(a_extra_has_head, extra_valid, out_valid)
  `CSL_ASSERT_NOW(a_first_of_pair, out_valid && !last_of_run, extra_valid)
  `CSL_ASSERT_NOW(a_run_nonempty, mode != MODE_IDLE, run_length != '0)
  `CSL_ASSERT_NOW(a_cand_only_in_word, mode != MODE_WORD, cand == '0)
  `CSL_ASSERT_NEXT(a_eos_to_idle, accept && end_of_stream, mode == MODE_IDLE)

endmodule

`default_nettype wire
